// ===== sv/bbiou_pkg.sv =====
// ----------------------------------------------------------------------------
// bbiou_pkg
// Shared constants for the buffered box IoU block: configuration register
// indexes, reset values, scale format and the degenerate union floor.
// ----------------------------------------------------------------------------
package bbiou_pkg;

    // Buffer scale format, Q2.8
    localparam int SCALE_W    = 10;
    localparam int SCALE_FRAC = 8;

    // Configuration port index width
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIGHT_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THR   = 2'd2;

    // Register reset values
    localparam int TIGHT_SCALE_RST = 77;
    localparam int WIDE_SCALE_RST  = 128;
    localparam int MATCH_THR_RST   = 19661;

    // Union areas at or below this many Q.16 LSB (about 2.4e-4 px^2) give zero
    localparam int UNION_FLOOR = 16;

endpackage

// ===== sv/buffered_box_iou.sv =====
// ----------------------------------------------------------------------------
// buffered_box_iou
// Buffered intersection over union of two axis-aligned boxes, fully
// pipelined, with a configurable match threshold flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transfer carries a box pair; tuser picks the
//   wide (1) or tight (0) buffer scale. Each box is grown by scale times its
//   width/height on every side, then the IoU of the grown boxes is returned.
//   Output stream (m_axis_*): one transfer per input transfer, in order;
//   tdata holds the IoU in Q1.IOU_FRAC_BITS (truncated), tuser the flag that
//   the IoU reaches the match threshold.
//   Config channel (i_cfg_*): index 0 tight scale, 1 wide scale, 2 threshold;
//   always ready, write only while no item is in flight.
// Timing:
//   Edge growth, area products, intersection product, union, one restoring
//   divide stage per quotient bit, then the output register. One item per
//   cycle while the output transfer is not held off.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults. When the
//   output transfer is held off, the whole pipeline freezes and s_axis_tready
//   drops; no data is lost or repeated.
// ----------------------------------------------------------------------------
module buffered_box_iou #(
    parameter int COORD_BITS    = 16,
    parameter int IOU_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Fields from bit 0: a_left, a_top, a_width, a_height,
    //                    b_left, b_top, b_width, b_height, zero fill
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0]         s_axis_tdata,
    // Fields from bit 0: use_wide_buffer
    input  logic [0:0]                                  s_axis_tuser,

    // Fields from bit 0: iou, zero fill
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [((IOU_FRAC_BITS+1+7)/8)*8-1:0]        m_axis_tdata,
    // Fields from bit 0: meets_threshold
    output logic [0:0]                                  m_axis_tuser,

    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [bbiou_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [((IOU_FRAC_BITS+1 > bbiou_pkg::SCALE_W) ?
                   IOU_FRAC_BITS+1 : bbiou_pkg::SCALE_W)-1:0] i_cfg_data
);
    import bbiou_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = IOU_FRAC_BITS;
    localparam int DW = C + 9;          // size * scale
    localparam int E  = C + 11;         // grown edge, signed Q.8
    localparam int X  = C + 11;         // grown extent, unsigned Q.8
    localparam int A  = 2 * X;          // area, Q.16
    localparam int U  = A + 1;          // union
    localparam int OW = ((F + 1 + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0] r_tight;
    logic [SCALE_W-1:0] r_wide;
    logic [F:0]         r_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tight <= SCALE_W'(TIGHT_SCALE_RST);
            r_wide  <= SCALE_W'(WIDE_SCALE_RST);
            r_thr   <= (F+1)'(MATCH_THR_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIGHT_SCALE: r_tight <= i_cfg_data[SCALE_W-1:0];
                REG_WIDE_SCALE:  r_wide  <= i_cfg_data[SCALE_W-1:0];
                REG_MATCH_THR:   r_thr   <= i_cfg_data[F:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: freeze everything while the output is held
    // ------------------------------------------------------------------
    logic w_en;
    logic r_out_valid;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // Edge growth helpers
    // ------------------------------------------------------------------
    function automatic logic signed [E-1:0] f_lo(logic signed [C-1:0] pos,
                                                 logic [DW-1:0] d);
        f_lo = (E'(pos) <<< SCALE_FRAC) - $signed(E'(d));
    endfunction

    function automatic logic signed [E-1:0] f_hi(logic signed [C-1:0] pos,
                                                 logic [C-2:0] size,
                                                 logic [DW-1:0] d);
        f_hi = (E'(pos) <<< SCALE_FRAC) + $signed(E'({size, 8'b0}))
               + $signed(E'(d));
    endfunction

    function automatic logic [X-1:0] f_ext(logic [C-2:0] size, logic [DW-1:0] d);
        f_ext = X'({size, 8'b0}) + X'({d, 1'b0});
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: unpack, scale sizes, grow edges
    // ------------------------------------------------------------------
    logic signed [C-1:0] w_al, w_at, w_bl, w_bt;
    logic [C-2:0]        w_aw, w_ah, w_bw, w_bh;
    logic [SCALE_W-1:0]  w_scale;
    logic [DW-1:0]       w_daw, w_dah, w_dbw, w_dbh;

    assign w_al = s_axis_tdata[0 +: C];
    assign w_at = s_axis_tdata[C +: C];
    assign w_aw = s_axis_tdata[2*C +: C-1];
    assign w_ah = s_axis_tdata[3*C-1 +: C-1];
    assign w_bl = s_axis_tdata[4*C-2 +: C];
    assign w_bt = s_axis_tdata[5*C-2 +: C];
    assign w_bw = s_axis_tdata[6*C-2 +: C-1];
    assign w_bh = s_axis_tdata[7*C-3 +: C-1];

    assign w_scale = s_axis_tuser[0] ? r_wide : r_tight;
    assign w_daw   = DW'(w_aw) * DW'(w_scale);
    assign w_dah   = DW'(w_ah) * DW'(w_scale);
    assign w_dbw   = DW'(w_bw) * DW'(w_scale);
    assign w_dbh   = DW'(w_bh) * DW'(w_scale);

    logic                r_v1;
    logic signed [E-1:0] r_ax0, r_ax1, r_ay0, r_ay1, r_bx0, r_bx1, r_by0, r_by1;
    logic [X-1:0]        r_aex, r_aey, r_bex, r_bey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax0 <= f_lo(w_al, w_daw);
            r_ax1 <= f_hi(w_al, w_aw, w_daw);
            r_ay0 <= f_lo(w_at, w_dah);
            r_ay1 <= f_hi(w_at, w_ah, w_dah);
            r_bx0 <= f_lo(w_bl, w_dbw);
            r_bx1 <= f_hi(w_bl, w_bw, w_dbw);
            r_by0 <= f_lo(w_bt, w_dbh);
            r_by1 <= f_hi(w_bt, w_bh, w_dbh);
            r_aex <= f_ext(w_aw, w_daw);
            r_aey <= f_ext(w_ah, w_dah);
            r_bex <= f_ext(w_bw, w_dbw);
            r_bey <= f_ext(w_bh, w_dbh);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: box areas, overlap extents
    // ------------------------------------------------------------------
    logic signed [E-1:0] w_ix0, w_ix1, w_iy0, w_iy1;

    assign w_ix0 = (r_ax0 > r_bx0) ? r_ax0 : r_bx0;
    assign w_ix1 = (r_ax1 < r_bx1) ? r_ax1 : r_bx1;
    assign w_iy0 = (r_ay0 > r_by0) ? r_ay0 : r_by0;
    assign w_iy1 = (r_ay1 < r_by1) ? r_ay1 : r_by1;

    logic         r_v2;
    logic [A-1:0] r2_area_a, r2_area_b;
    logic [X-1:0] r2_ixw, r2_iyw;
    logic         r2_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_area_a <= A'(r_aex) * A'(r_aey);
            r2_area_b <= A'(r_bex) * A'(r_bey);
            r2_ixw    <= X'(w_ix1 - w_ix0);
            r2_iyw    <= X'(w_iy1 - w_iy0);
            r2_ovl    <= (w_ix1 > w_ix0) && (w_iy1 > w_iy0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: intersection area, zero when the boxes do not overlap
    // ------------------------------------------------------------------
    logic         r_v3;
    logic [A-1:0] r3_area_a, r3_area_b, r3_inter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_area_a <= r2_area_a;
            r3_area_b <= r2_area_b;
            r3_inter  <= r2_ovl ? A'(r2_ixw) * A'(r2_iyw) : '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: union, special-case flags, divider seed
    // ------------------------------------------------------------------
    logic [U-1:0] w_uni;

    assign w_uni = U'(r3_area_a) + U'(r3_area_b) - U'(r3_inter);

    logic [U-1:0] r_rem   [0:F];
    logic [U-1:0] r_uni   [0:F];
    logic [F-1:0] r_q     [0:F];
    logic         r_full  [0:F];
    logic         r_degen [0:F];
    logic         r_vd    [0:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (w_en) begin
            r_vd[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0]   <= U'(r3_inter);
            r_uni[0]   <= w_uni;
            r_q[0]     <= '0;
            r_full[0]  <= U'(r3_inter) >= w_uni;
            r_degen[0] <= w_uni <= U'(UNION_FLOOR);
        end
    end

    // ------------------------------------------------------------------
    // Restoring divide: one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < F; k++) begin : g_div
        logic [U:0]   w_rem2;
        logic         w_ge;
        logic [U-1:0] w_rem_n;

        assign w_rem2  = {r_rem[k], 1'b0};
        assign w_ge    = w_rem2 >= (U+1)'(r_uni[k]);
        assign w_rem_n = w_ge ? U'(w_rem2 - (U+1)'(r_uni[k])) : U'(w_rem2);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (w_en) begin
                r_vd[k+1] <= r_vd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k+1]   <= w_rem_n;
                r_uni[k+1]   <= r_uni[k];
                r_q[k+1]     <= {r_q[k][F-2:0], w_ge};
                r_full[k+1]  <= r_full[k];
                r_degen[k+1] <= r_degen[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: resolve special cases, compare against threshold
    // ------------------------------------------------------------------
    logic [F:0] w_iou;
    logic [F:0] r_out_iou;
    logic       r_out_meets;

    always_comb begin
        if (r_degen[F]) begin
            w_iou = '0;
        end else if (r_full[F]) begin
            w_iou = (F+1)'(1) << F;
        end else begin
            w_iou = {1'b0, r_q[F]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vd[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_iou   <= w_iou;
            r_out_meets <= w_iou >= r_thr;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = OW'(r_out_iou);
    assign m_axis_tuser[0] = r_out_meets;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Seed remainder never reaches the union unless the full flag covers it
    a_seed_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[0] && !r_full[0]) |-> (r_rem[0] < r_uni[0]))
        else $error("divider seed remainder not below union");

    // Remainder stays below the divisor through the last divide stage
    a_last_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[F] && !r_full[F]) |-> (r_rem[F] < r_uni[F]))
        else $error("divider remainder escaped its bound");

    // A delivered IoU never exceeds one
    a_iou_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_iou <= ((F+1)'(1) << F)))
        else $error("iou above one");

    // A frozen pipeline keeps its result for the held transfer
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_iou)
                                            && $stable(r_out_meets)))
        else $error("held result changed");

endmodule
